// ===== rtl/wtbe_pkg.sv =====
// ----------------------------------------------------------------------------
// wtbe_pkg
// Shared widths, codes and constants of the windowed trig basis evaluator.
// ----------------------------------------------------------------------------
package wtbe_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 20;

    localparam int IDX_W      = 16;   // basis_index and time_step
    localparam int BPB_W      = 8;
    localparam int SPB_W      = 16;
    localparam int AC_W       = 2;
    localparam int WORD_W     = 32;
    localparam int IN_W       = 160;
    localparam int OUT_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int XY_W = 34;         // CORDIC x/y, Q2.30 with headroom
    localparam int Z_W  = 33;         // CORDIC angle, Q2.30

    localparam logic signed [XY_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [XY_W-1:0] ONE_Q30      = 34'sd1073741824;
    localparam logic signed [30:0]     TURN_SCALE   = 31'sd683565276;
    localparam logic [30:0]            QUARTER_RAD  = 31'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ASSET_COUNT     = 2'd0,
        CFG_BASIS_PER_BLOCK = 2'd1,
        CFG_STEPS_PER_BLOCK = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MODE_ZERO = 2'd0,
        MODE_ONE  = 2'd1,
        MODE_TRIG = 2'd2
    } t_mode;

    // atan(2^-i) in Q2.30
    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:  v = 31'd843314857;
            5'd1:  v = 31'd497837830;
            5'd2:  v = 31'd263043837;
            5'd3:  v = 31'd133525159;
            5'd4:  v = 31'd67021687;
            5'd5:  v = 31'd33543516;
            5'd6:  v = 31'd16775851;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194283;
            5'd9:  v = 31'd2097149;
            5'd30: v = 31'd1;
            5'd31: v = 31'd0;
            default: v = 31'd1 << (5'd30 - idx);
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/windowed_trig_basis_eval.sv =====
// ----------------------------------------------------------------------------
// windowed_trig_basis_eval
// Regression basis evaluator: windowed cos/sin basis times price, Q16.16.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction in and one out per clock whenever the
// output is not stalled. The front is a chain of 16 restoring-division cells
// that forms basis_index/basis_per_block, its remainder j and
// time_step/steps_per_block; then five setup stages build the angle and phase,
// a chain of CORDIC_STAGES rotation cells per asset produces cos/sin, and
// three stages scale by price, round and saturate.
// The whole chain advances together whenever the output register is empty or
// being taken, so input ready follows the output side only. Every input
// yields exactly one result; o_m_tuser low marks a basis that does not apply.
// Configuration may be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module windowed_trig_basis_eval #(
    parameter int FRAC_BITS     = wtbe_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = wtbe_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wtbe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wtbe_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: basis_index[15:0], time_step[31:16], price0[63:32],
    //        price1[95:64], coord0[127:96], coord1[159:128]
    input  logic [wtbe_pkg::IN_W-1:0]         i_s_tdata,
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: value0[31:0], value1[63:32]
    output logic [wtbe_pkg::OUT_W-1:0]        o_m_tdata,
    // tuser: present[0]
    output logic                              o_m_tuser
);
    import wtbe_pkg::*;

    localparam int NDIV = IDX_W;
    localparam int NCTL = CORDIC_STAGES + 7;
    localparam int CTL_PHASE = 3;
    localparam int CTL_CORD  = 4 + CORDIC_STAGES;
    localparam int CTL_POST  = 5 + CORDIC_STAGES;
    localparam int CTL_MULT  = 6 + CORDIC_STAGES;
    localparam logic [39:0] LIM_WIDE   = 40'(9)  << FRAC_BITS;
    localparam logic [39:0] LIM_NARROW = 40'(11) << FRAC_BITS;
    localparam logic [39:0] LIM_DIFF   = 40'(15) << FRAC_BITS;
    localparam logic signed [65:0] HALF_Q30 = 66'sd536870912;
    localparam logic signed [35:0] SAT_MAX  = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN  = -36'sd2147483648;

    typedef struct packed {
        logic signed [WORD_W-1:0] price0;
        logic signed [WORD_W-1:0] price1;
        logic signed [WORD_W-1:0] coord0;
        logic signed [WORD_W-1:0] coord1;
    } t_item;

    typedef struct packed {
        t_mode      mode;
        logic       odd;
        logic [1:0] sh;
        logic [1:0] quad;
    } t_lane;

    typedef struct packed {
        logic                     present;
        logic signed [WORD_W-1:0] price0;
        logic signed [WORD_W-1:0] price1;
        t_lane [1:0]              lane;
    } t_ctl;

    // configuration registers
    logic [AC_W-1:0]  r_asset_count;
    logic [BPB_W-1:0] r_basis_per_block;
    logic [SPB_W-1:0] r_steps_per_block;

    logic w_adv;

    // divider chain
    logic [IDX_W-1:0] w_kd [0:NDIV];
    logic [IDX_W-1:0] w_kq [0:NDIV];
    logic [BPB_W-1:0] w_kr [0:NDIV];
    logic [IDX_W-1:0] w_nd [0:NDIV];
    logic [IDX_W-1:0] w_nq [0:NDIV];
    logic [SPB_W-1:0] w_nr [0:NDIV];
    t_item            r_dp [0:NDIV-1];
    logic             r_dv [0:NDIV-1];
    t_item            w_in;

    // setup stage signals
    logic                     w_present, w_two, w_near;
    logic [BPB_W-1:0]         w_j;
    logic signed [32:0]       w_sum, w_diff;
    logic [32:0]              w_dmag;
    logic signed [32:0]       w_arg [2];
    logic signed [8:0]        w_k   [2];
    logic                     w_en  [2];
    logic                     w_nar;
    logic [32:0]              w_mag [2];
    logic [39:0]              w_mv  [2];
    logic signed [8:0]        w_m   [2];
    logic signed [10:0]       w_f   [2];
    t_ctl                     w_ctl0;

    // per-lane pipeline registers
    logic signed [32:0]   r_arg   [2];
    logic signed [10:0]   r_f     [2];
    logic signed [43:0]   r_a     [2];
    logic [53:0]          r_pplo  [2];
    logic signed [49:0]   r_pphi  [2];
    logic [63:0]          w_prod  [2];
    logic [31:0]          w_phase [2];
    logic [29:0]          r_rem   [2];
    logic signed [Z_W-1:0] r_z    [2];
    logic signed [XY_W-1:0] w_x [2][0:CORDIC_STAGES];
    logic signed [XY_W-1:0] w_y [2][0:CORDIC_STAGES];
    logic signed [Z_W-1:0]  w_z [2][0:CORDIC_STAGES];
    logic signed [XY_W-1:0] w_c [2];
    logic signed [XY_W-1:0] w_s [2];
    logic signed [XY_W-1:0] w_v [2];
    logic signed [XY_W-1:0] r_v [2];
    logic signed [65:0]     r_prod [2];
    logic signed [65:0]     w_rnd  [2];
    logic signed [WORD_W-1:0] w_val [2];

    t_ctl r_ctl [0:NCTL-1];
    t_ctl n_ctl [0:NCTL-1];
    logic r_vld [0:NCTL-1];

    logic                r_ov;
    logic [OUT_W-1:0]    r_odata;
    logic                r_ouser;

    // ------------------------------------------------------------------
    // Configuration: always ready, masked to register width.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asset_count     <= AC_W'(1);
            r_basis_per_block <= BPB_W'(48);
            r_steps_per_block <= SPB_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_ASSET_COUNT:     r_asset_count     <= i_cfg_data[AC_W-1:0];
                CFG_BASIS_PER_BLOCK: r_basis_per_block <= i_cfg_data[BPB_W-1:0];
                CFG_STEPS_PER_BLOCK: r_steps_per_block <= i_cfg_data[SPB_W-1:0];
                default: ;  // index outside the register list: drop
            endcase
        end
    end

    // Advance the whole chain when the output slot is free or being taken.
    assign w_adv      = !r_ov || i_m_tready;
    assign o_s_tready = w_adv;

    // ------------------------------------------------------------------
    // Division chain: quotient bits MSB first, one per cell.
    // ------------------------------------------------------------------
    assign w_in.price0 = i_s_tdata[63:32];
    assign w_in.price1 = i_s_tdata[95:64];
    assign w_in.coord0 = i_s_tdata[127:96];
    assign w_in.coord1 = i_s_tdata[159:128];

    assign w_kd[0] = i_s_tdata[15:0];
    assign w_kq[0] = '0;
    assign w_kr[0] = '0;
    assign w_nd[0] = i_s_tdata[31:16];
    assign w_nq[0] = '0;
    assign w_nr[0] = '0;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        wtbe_div_cell #(.DW(BPB_W)) u_kdiv (
            .i_clk (i_clk), .i_en (w_adv),
            .i_dvd (w_kd[g]), .i_quo (w_kq[g]), .i_rem (w_kr[g]),
            .i_dsr (r_basis_per_block),
            .o_dvd (w_kd[g+1]), .o_quo (w_kq[g+1]), .o_rem (w_kr[g+1])
        );
        wtbe_div_cell #(.DW(SPB_W)) u_ndiv (
            .i_clk (i_clk), .i_en (w_adv),
            .i_dvd (w_nd[g]), .i_quo (w_nq[g]), .i_rem (w_nr[g]),
            .i_dsr (r_steps_per_block),
            .o_dvd (w_nd[g+1]), .o_quo (w_nq[g+1]), .o_rem (w_nr[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dp[0] <= w_in;
            for (int i = 1; i < NDIV; i++) begin
                r_dp[i] <= r_dp[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NDIV; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_dv[0] <= i_s_tvalid;
            for (int i = 1; i < NDIV; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Setup: block match, local index j, per-asset argument and window.
    // ------------------------------------------------------------------
    assign w_j       = w_kr[NDIV];
    assign w_present = (r_asset_count != '0) && (r_basis_per_block != '0) &&
                       (r_steps_per_block != '0) && (w_kq[NDIV] == w_nq[NDIV]);
    assign w_two     = r_asset_count[1];
    assign w_sum     = 33'(r_dp[NDIV-1].coord0) + 33'(r_dp[NDIV-1].coord1);
    assign w_diff    = 33'(r_dp[NDIV-1].price0) - 33'(r_dp[NDIV-1].price1);
    assign w_dmag    = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_near    = (40'(w_dmag) < LIM_DIFF);
    assign w_nar     = !w_near;

    always_comb begin
        w_arg[0] = 33'(r_dp[NDIV-1].coord0);
        w_arg[1] = 33'(r_dp[NDIV-1].coord1);
        w_k[0]   = '0;
        w_k[1]   = '0;
        w_en[0]  = 1'b0;
        w_en[1]  = 1'b0;
        if (w_near) begin
            if (w_j < BPB_W'(12)) begin
                w_arg[0] = w_sum;
                w_arg[1] = w_sum;
                w_k[0]   = $signed({1'b0, w_j});
                w_k[1]   = $signed({1'b0, w_j});
                w_en[0]  = 1'b1;
                w_en[1]  = 1'b1;
            end else if (w_j < BPB_W'(24)) begin
                w_k[0]   = $signed({1'b0, w_j}) - 9'sd12;
                w_k[1]   = $signed({1'b0, w_j}) - 9'sd12;
                w_en[0]  = 1'b1;
                w_en[1]  = 1'b1;
            end
        end else begin
            if (w_j < BPB_W'(36)) begin
                w_k[0]   = $signed({1'b0, w_j}) - 9'sd24;
                w_k[1]   = $signed({1'b0, w_j}) - 9'sd24;
                w_en[0]  = (r_dp[NDIV-1].price0 >= r_dp[NDIV-1].price1);
                w_en[1]  = (r_dp[NDIV-1].price0 <= r_dp[NDIV-1].price1);
            end else if (w_j < BPB_W'(48)) begin
                w_k[0]   = $signed({1'b0, w_j}) - 9'sd36;
                w_k[1]   = $signed({1'b0, w_j}) - 9'sd36;
                w_en[0]  = 1'b1;
                w_en[1]  = 1'b1;
            end
        end
        // one-asset mode: plain trig of coord0 with multiple j
        if (!w_two) begin
            w_arg[0] = 33'(r_dp[NDIV-1].coord0);
            w_k[0]   = $signed({1'b0, w_j});
        end
    end

    always_comb begin
        w_ctl0.present = r_dv[NDIV-1] && w_present;
        w_ctl0.price0  = r_dp[NDIV-1].price0;
        w_ctl0.price1  = r_dp[NDIV-1].price1;
        for (int l = 0; l < 2; l++) begin
            w_mag[l] = w_arg[l][32] ? 33'(-w_arg[l]) : 33'(w_arg[l]);
            w_mv[l]  = w_nar ? (40'(w_mag[l]) << 5) + (40'(w_mag[l]) << 4) +
                               (40'(w_mag[l]) << 1)
                             : (40'(w_mag[l]) << 4) + (40'(w_mag[l]) << 3) +
                               40'(w_mag[l]);
            w_m[l]   = (w_k[l] + 9'($signed({1'b0, w_k[l][0]}))) >>> 1;
            w_f[l]   = w_two ? (11'(w_m[l]) <<< 2) + 11'(w_m[l]) : 11'(w_m[l]);
            w_ctl0.lane[l].odd  = w_k[l][0];
            w_ctl0.lane[l].quad = '0;
            w_ctl0.lane[l].sh   = !w_two ? 2'd0 : (w_nar ? 2'd1 : 2'd2);
            if (!w_present) begin
                w_ctl0.lane[l].mode = MODE_ZERO;
            end else if (!w_two) begin
                w_ctl0.lane[l].mode = (l == 0) ? MODE_TRIG : MODE_ZERO;
            end else if (!w_en[l]) begin
                w_ctl0.lane[l].mode = MODE_ZERO;
            end else if (w_mv[l] < (w_nar ? LIM_NARROW : LIM_WIDE)) begin
                w_ctl0.lane[l].mode = MODE_TRIG;
            end else if (!w_arg[l][32]) begin
                w_ctl0.lane[l].mode = MODE_ONE;
            end else begin
                w_ctl0.lane[l].mode = MODE_ZERO;
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle, phase in turns, radians.
    // ------------------------------------------------------------------
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_prod[l] = 64'(r_pplo[l]) + (64'(r_pphi[l]) << 24);
            case (r_ctl[CTL_PHASE-1].lane[l].sh)
                2'd0:    w_phase[l] = w_prod[l][FRAC_BITS +: 32];
                2'd1:    w_phase[l] = w_prod[l][FRAC_BITS+1 +: 32];
                default: w_phase[l] = w_prod[l][FRAC_BITS+2 +: 32];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < 2; l++) begin
                r_arg[l]  <= w_arg[l];
                r_f[l]    <= w_f[l];
                r_a[l]    <= 44'(r_arg[l]) * 44'(r_f[l]);
                r_pplo[l] <= 54'(r_a[l][23:0]) * 54'(TURN_SCALE);
                r_pphi[l] <= 50'($signed(r_a[l][43:24])) * 50'(TURN_SCALE);
                r_rem[l]  <= w_phase[l][29:0];
                r_z[l]    <= Z_W'((61'(r_rem[l]) * 61'(QUARTER_RAD)) >> 30);
            end
        end
    end

    // ------------------------------------------------------------------
    // CORDIC chains, one per asset.
    // ------------------------------------------------------------------
    for (genvar l = 0; l < 2; l++) begin : g_lane
        assign w_x[l][0] = CORDIC_START;
        assign w_y[l][0] = '0;
        assign w_z[l][0] = r_z[l];
        for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
            wtbe_cordic_cell #(.SHIFT(s)) u_cell (
                .i_clk (i_clk), .i_en (w_adv),
                .i_x (w_x[l][s]),   .i_y (w_y[l][s]),   .i_z (w_z[l][s]),
                .o_x (w_x[l][s+1]), .o_y (w_y[l][s+1]), .o_z (w_z[l][s+1])
            );
        end
    end

    // ------------------------------------------------------------------
    // Quadrant fold, window override, price scaling, round and saturate.
    // ------------------------------------------------------------------
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            case (r_ctl[CTL_CORD].lane[l].quad)
                2'd0: begin
                    w_c[l] = w_x[l][CORDIC_STAGES];
                    w_s[l] = w_y[l][CORDIC_STAGES];
                end
                2'd1: begin
                    w_c[l] = -w_y[l][CORDIC_STAGES];
                    w_s[l] = w_x[l][CORDIC_STAGES];
                end
                2'd2: begin
                    w_c[l] = -w_x[l][CORDIC_STAGES];
                    w_s[l] = -w_y[l][CORDIC_STAGES];
                end
                default: begin
                    w_c[l] = w_y[l][CORDIC_STAGES];
                    w_s[l] = -w_x[l][CORDIC_STAGES];
                end
            endcase
            case (r_ctl[CTL_CORD].lane[l].mode)
                MODE_TRIG: w_v[l] = r_ctl[CTL_CORD].lane[l].odd ? w_s[l] : w_c[l];
                MODE_ONE:  w_v[l] = ONE_Q30;
                default:   w_v[l] = '0;
            endcase
            w_rnd[l] = (r_prod[l] + HALF_Q30) >>> 30;
            if (w_rnd[l] > 66'(SAT_MAX)) begin
                w_val[l] = WORD_W'(SAT_MAX);
            end else if (w_rnd[l] < 66'(SAT_MIN)) begin
                w_val[l] = WORD_W'(SAT_MIN);
            end else begin
                w_val[l] = w_rnd[l][WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v[0]    <= w_v[0];
            r_v[1]    <= w_v[1];
            r_prod[0] <= 66'(r_v[0]) * 66'(r_ctl[CTL_POST].price0);
            r_prod[1] <= 66'(r_v[1]) * 66'(r_ctl[CTL_POST].price1);
            r_odata   <= {w_val[1], w_val[0]};
            r_ouser   <= r_ctl[CTL_MULT].present;
        end
    end

    // ------------------------------------------------------------------
    // Side-band chain; the quadrant joins at the phase stage.
    // ------------------------------------------------------------------
    always_comb begin
        n_ctl[0] = w_ctl0;
        for (int i = 1; i < NCTL; i++) begin
            n_ctl[i] = r_ctl[i-1];
        end
        n_ctl[CTL_PHASE].lane[0].quad = w_phase[0][31:30];
        n_ctl[CTL_PHASE].lane[1].quad = w_phase[1][31:30];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NCTL; i++) begin
                r_ctl[i] <= n_ctl[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCTL; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= r_dv[NDIV-1];
            for (int i = 1; i < NCTL; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_ov <= r_vld[NCTL-1];
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule

// ===== rtl/wtbe_div_cell.sv =====
// ----------------------------------------------------------------------------
// wtbe_div_cell
// One restoring-division cell: retires one quotient bit per stage.
// ----------------------------------------------------------------------------
module wtbe_div_cell #(
    parameter int DW = 8
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [wtbe_pkg::IDX_W-1:0] i_dvd,
    input  logic [wtbe_pkg::IDX_W-1:0] i_quo,
    input  logic [DW-1:0]             i_rem,
    input  logic [DW-1:0]             i_dsr,
    output logic [wtbe_pkg::IDX_W-1:0] o_dvd,
    output logic [wtbe_pkg::IDX_W-1:0] o_quo,
    output logic [DW-1:0]             o_rem
);
    import wtbe_pkg::*;

    logic [DW:0] w_trial;
    logic [DW:0] w_diff;
    logic        w_ge;
    logic [IDX_W-1:0] r_dvd, r_quo;
    logic [DW-1:0]    r_rem;

    assign w_trial = {i_rem, i_dvd[IDX_W-1]};
    assign w_diff  = w_trial - {1'b0, i_dsr};
    assign w_ge    = (w_trial >= {1'b0, i_dsr});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvd <= {i_dvd[IDX_W-2:0], 1'b0};
            r_quo <= {i_quo[IDX_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_dvd = r_dvd;
    assign o_quo = r_quo;
    assign o_rem = r_rem;

endmodule

// ===== rtl/wtbe_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// wtbe_cordic_cell
// One CORDIC rotation stage in rotation mode with a fixed shift.
// ----------------------------------------------------------------------------
module wtbe_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [wtbe_pkg::XY_W-1:0]  i_x,
    input  logic signed [wtbe_pkg::XY_W-1:0]  i_y,
    input  logic signed [wtbe_pkg::Z_W-1:0]   i_z,
    output logic signed [wtbe_pkg::XY_W-1:0]  o_x,
    output logic signed [wtbe_pkg::XY_W-1:0]  o_y,
    output logic signed [wtbe_pkg::Z_W-1:0]   o_z
);
    import wtbe_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = Z_W'($signed({1'b0, atan_q30(5'(SHIFT))}));

    logic signed [XY_W-1:0] w_dx, w_dy;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;

    assign w_dx = i_y >>> SHIFT;
    assign w_dy = i_x >>> SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[Z_W-1]) begin
                r_x <= i_x - w_dx;
                r_y <= i_y + w_dy;
                r_z <= i_z - ATAN;
            end else begin
                r_x <= i_x + w_dx;
                r_y <= i_y - w_dy;
                r_z <= i_z + ATAN;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ===== rtl/wtbe_checker.sv =====
// ----------------------------------------------------------------------------
// wtbe_checker
// Port-level checks of the basis evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module wtbe_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [wtbe_pkg::OUT_W-1:0]     o_m_tdata,
    input logic                           o_m_tuser
);
    import wtbe_pkg::*;

    // hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
                                      $stable(o_m_tuser))
        else $error("stalled output transaction changed");

    // absent basis carries zero values
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("absent result with nonzero values");

    // input side never waits on an empty output register
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output is empty");

    // reset flushes the output
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // configuration writes are never back-pressured
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind windowed_trig_basis_eval wtbe_checker u_wtbe_checker (.*);
